@@ src/tdpb_pkg.sv @@
// Package for the tail drop packet buffer.
// Holds the widths, the queue depth and the sequencer state type.
// Used by the channel interfaces, the ring memory and the top level.
package tdpb_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 40;
    localparam int ARR_W       = 32;
    localparam int PROC_W      = 20;
    localparam int SIZE_W      = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic {
        S_IDLE,
        S_CHECK
    } t_state;

endpackage

@@ src/tdpb_if.sv @@
// Channel interfaces for the tail drop packet buffer: packet input,
// result output and buffer size configuration.
// Depends on tdpb_pkg for the field widths.
interface tdpb_in_if;
    logic                        valid;
    logic                        ready;
    logic [tdpb_pkg::ARR_W-1:0]  arr_tick;
    logic [tdpb_pkg::PROC_W-1:0] proc_ticks;

    modport source (output valid, output arr_tick, output proc_ticks, input ready);
    modport sink   (input valid, input arr_tick, input proc_ticks, output ready);
endinterface

interface tdpb_out_if;
    logic                        valid;
    logic                        ready;
    logic                        dropped;
    logic [tdpb_pkg::TIME_W-1:0] start_tick;

    modport source (output valid, output dropped, output start_tick, input ready);
    modport sink   (input valid, input dropped, input start_tick, output ready);
endinterface

interface tdpb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tdpb_pkg::SIZE_W-1:0] buffer_size;

    modport source (output valid, output buffer_size, input ready);
    modport sink   (input valid, input buffer_size, output ready);
endinterface

@@ src/tdpb_ring.sv @@
// Ring memory of finish times for the tail drop packet buffer.
// One write port and one registered read port; depends on tdpb_pkg.
module tdpb_ring (
    input  logic            i_clk,
    input  logic            i_we,
    input  tdpb_pkg::t_idx  i_waddr,
    input  tdpb_pkg::t_time i_wdata,
    input  tdpb_pkg::t_idx  i_raddr,
    output tdpb_pkg::t_time o_rdata
);

    tdpb_pkg::t_time r_mem [tdpb_pkg::QUEUE_DEPTH];
    tdpb_pkg::t_time r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/tail_drop_packet_buffer_unit.sv @@
// Top level of the tail drop packet buffer.
// Depends on tdpb_pkg, the channel interfaces in tdpb_if and tdpb_ring.
//
// Each packet transfer on i_in carries an arrival time and a processing
// time. The unit keeps the finish times of held packets in a ring memory,
// retires from the head every entry that finishes at or before the
// arrival, then accepts the packet (start at its arrival when the queue is
// empty, else at the last finish time) or drops it when the queue is not
// empty and holds at least buffer_size entries or all QUEUE_DEPTH slots.
// One result transfer on o_out follows each packet. The head entry is
// read from the registered read port of the ring memory, and each retire
// step reads the next head. The decision step after the last retire step
// loads the output register; i_in is ready again as the result appears.
// If the receiver stalls, the finished result waits in the output register
// and the next packet is taken and processed, holding its decision until
// the output register frees. i_cfg writes buffer_size and is always ready.
// Reset empties the queue, clears the last finish time and sets
// buffer_size to 64; the ring memory contents need no clearing.
module tail_drop_packet_buffer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdpb_in_if.sink     i_in,
    tdpb_out_if.source  o_out,
    tdpb_cfg_if.sink    i_cfg
);

    tdpb_pkg::t_state r_state, n_state;
    tdpb_pkg::t_idx   r_head, n_head;
    tdpb_pkg::t_cnt   r_count, n_count;
    tdpb_pkg::t_time  r_last, n_last;
    logic [tdpb_pkg::SIZE_W-1:0] r_size;
    logic             r_out_valid, n_out_valid;
    logic             r_dropped, n_dropped;
    tdpb_pkg::t_time  r_start, n_start;
    logic [tdpb_pkg::ARR_W-1:0]  r_arrival, n_arrival;
    logic [tdpb_pkg::PROC_W-1:0] r_proc, n_proc;

    logic            ring_we;
    tdpb_pkg::t_idx  ring_waddr;
    tdpb_pkg::t_time ring_wdata;
    tdpb_pkg::t_idx  ring_raddr;
    tdpb_pkg::t_time ring_rdata;

    tdpb_pkg::t_time         arrival_ext;
    tdpb_pkg::t_idx          head_inc;
    logic [tdpb_pkg::IDX_W:0] tail_sum;
    tdpb_pkg::t_idx          tail_slot;
    logic                    retire;
    logic                    out_free;
    logic                    has_room;
    tdpb_pkg::t_time         add_base;
    logic [tdpb_pkg::TIME_W:0] add_sum;
    tdpb_pkg::t_time         finish;

    tdpb_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    assign i_in.ready       = (r_state == tdpb_pkg::S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.dropped    = r_dropped;
    assign o_out.start_tick = r_start;

    always_comb begin
        arrival_ext = tdpb_pkg::TIME_W'(r_arrival);
        head_inc    = (32'(r_head) == tdpb_pkg::QUEUE_DEPTH - 1) ?
                      '0 : r_head + tdpb_pkg::IDX_W'(1);
        tail_sum    = (tdpb_pkg::IDX_W + 1)'(r_head)
                    + (tdpb_pkg::IDX_W + 1)'(r_count);
        tail_slot   = (32'(tail_sum) >= tdpb_pkg::QUEUE_DEPTH) ?
                      tdpb_pkg::IDX_W'(32'(tail_sum) - tdpb_pkg::QUEUE_DEPTH) :
                      tdpb_pkg::IDX_W'(tail_sum);
        retire      = (r_count != '0) && (ring_rdata <= arrival_ext);
        out_free    = !r_out_valid || o_out.ready;
        has_room    = (32'(r_count) < 32'(r_size))
                   && (32'(r_count) < tdpb_pkg::QUEUE_DEPTH);
        add_base    = (r_count == '0) ? arrival_ext : r_last;
        add_sum     = {1'b0, add_base} + (tdpb_pkg::TIME_W + 1)'(r_proc);
        finish      = add_sum[tdpb_pkg::TIME_W] ? '1 : add_sum[tdpb_pkg::TIME_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_dropped   = r_dropped;
        n_start     = r_start;
        n_arrival   = r_arrival;
        n_proc      = r_proc;
        ring_we     = 1'b0;
        ring_waddr  = tail_slot;
        ring_wdata  = finish;
        ring_raddr  = r_head;

        unique case (r_state)
            tdpb_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_arrival = i_in.arr_tick;
                    n_proc    = i_in.proc_ticks;
                    n_state   = tdpb_pkg::S_CHECK;
                end
            end
            tdpb_pkg::S_CHECK: begin
                if (retire) begin
                    n_head     = head_inc;
                    n_count    = r_count - tdpb_pkg::CNT_W'(1);
                    ring_raddr = head_inc;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = tdpb_pkg::S_IDLE;
                    if (r_count == '0 || has_room) begin
                        n_dropped = 1'b0;
                        n_start   = add_base;
                        n_last    = finish;
                        n_count   = r_count + tdpb_pkg::CNT_W'(1);
                        ring_we   = 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                        n_start   = r_last;
                    end
                end
            end
            default: begin
                n_state = tdpb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpb_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_size      <= tdpb_pkg::SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_size <= i_cfg.buffer_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dropped <= n_dropped;
        r_start   <= n_start;
        r_arrival <= n_arrival;
        r_proc    <= n_proc;
    end

endmodule
